FILE: src/gmo_pkg.sv
// shared types and constants for the glide modulated oscillator
// no dependencies
package gmo_pkg;

  localparam int unsigned GLIDE_DECIMATION_DEF = 100;
  localparam int unsigned SINE_TABLE_BITS_DEF  = 10;

  localparam logic [31:0] FX_ONE      = 32'h0100_0000;
  localparam logic [31:0] FX_HALF     = 32'h0080_0000;
  localparam logic [31:0] SAT_MAX     = 32'h7fff_ffff;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_DEN_W = 32;

  typedef enum logic [2:0] {
    WAVE_SAW    = 3'd0,
    WAVE_SINE   = 3'd1,
    WAVE_COSINE = 3'd2,
    WAVE_SMOOTH = 3'd3,
    WAVE_SQUARE = 3'd4
  } wave_e;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_GLIDE  = 2'd1,
    FUNC_RESET  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_WAVEFORM      = 2'd0,
    CFG_FM_DEPTH      = 2'd1,
    CFG_AM_DEPTH      = 2'd2,
    CFG_SAMPLE_PERIOD = 2'd3
  } cfg_e;

endpackage

FILE: src/gmo_mul.sv
// shared signed 8.24 multiplier, product registered, floor of full product
// depends on nothing
module gmo_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  assign y_o = prod_q[55:24];

endmodule

FILE: src/gmo_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on gmo_pkg
module gmo_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [gmo_pkg::DIV_NUM_W-1:0]    dividend_i,
  input  logic [gmo_pkg::DIV_DEN_W-1:0]    divisor_i,
  output logic                             done_o,
  output logic [gmo_pkg::DIV_NUM_W-1:0]    quot_o
);

  localparam int unsigned CntW = $clog2(gmo_pkg::DIV_NUM_W + 1);

  logic [gmo_pkg::DIV_NUM_W-1:0] quo_q;
  logic [gmo_pkg::DIV_DEN_W:0]   rem_q;
  logic [gmo_pkg::DIV_DEN_W-1:0] den_q;
  logic [CntW-1:0]               cnt_q;
  logic                          done_q;
  logic [gmo_pkg::DIV_DEN_W:0]   shifted;
  logic [gmo_pkg::DIV_DEN_W+1:0] trial;

  assign shifted = {rem_q[gmo_pkg::DIV_DEN_W-1:0], quo_q[gmo_pkg::DIV_NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(gmo_pkg::DIV_NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[gmo_pkg::DIV_DEN_W+1]) begin
        rem_q <= trial[gmo_pkg::DIV_DEN_W:0];
      end else begin
        rem_q <= shifted;
      end
      quo_q <= {quo_q[gmo_pkg::DIV_NUM_W-2:0], ~trial[gmo_pkg::DIV_DEN_W+1]};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: src/glide_modulated_oscillator.sv
// oscillator top level: sequencer, state, sine table, config registers
// depends on gmo_pkg, gmo_mul, gmo_div
//
//  channel  | handshake              | payload
//  in       | in_valid_i / in_ready_o| func_i fm_voltage_i am_voltage_i target_step_i glide_time_i
//  out      | out_valid_o/out_ready_i| sample_o
//  cfg      | cfg_we_i               | cfg_addr_i cfg_wdata_i
//
// a sample beat steps the sequencer through glide, fm multiply, am multiply, wrap, table,
// output multiply and output load, which waits out any output stall and registers the result
// a glide beat runs a reciprocal multiply, then two divisions, then the increment multiply
// reset and set-frequency beats complete in idle; no clearing pass after reset
// in_ready_o is high only while the sequencer is idle
module glide_modulated_oscillator #(
  parameter int unsigned GlideDecimation = gmo_pkg::GLIDE_DECIMATION_DEF,
  parameter int unsigned SineTableBits   = gmo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] fm_voltage_i,
  input  logic [31:0] am_voltage_i,
  input  logic [31:0] target_step_i,
  input  logic [31:0] glide_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sample_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned CntW = (GlideDecimation > 1) ? $clog2(GlideDecimation) : 1;
  localparam int unsigned SinN = 1 << SineTableBits;
  localparam int unsigned SinQ = SinN / 4;
  localparam int unsigned AddrW = SineTableBits - 1;
  localparam int unsigned RecipL = $clog2(GlideDecimation);
  localparam logic [63:0] RecipM = ((64'd1 << (31 + RecipL)) + 64'(GlideDecimation) - 64'd1)
                                   / 64'(GlideDecimation);

  typedef logic [24:0] qtab_t [SinQ+1];

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= SinQ; i++) begin
      x    = (gmo_pkg::HALF_PI_Q30 * 64'(i)) / SinQ;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[i] = 25'((64'(sum) + 64'd32) >> 6);
    end
    return tab;
  endfunction

  localparam qtab_t QTab = build_qtab();

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_GLIDE    = 13'b0000000000010,
    ST_FM_MUL   = 13'b0000000000100,
    ST_AM_MUL   = 13'b0000000001000,
    ST_WRAP     = 13'b0000000010000,
    ST_TAB      = 13'b0000000100000,
    ST_OUT_MUL  = 13'b0000001000000,
    ST_OUT_LOAD = 13'b0000010000000,
    ST_DIV_T    = 13'b0000100000000,
    ST_DIV_RATE = 13'b0001000000000,
    ST_DIV_PROG = 13'b0010000000000,
    ST_INC_MUL  = 13'b0100000000000,
    ST_INC_SET  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  waveform_q;
  logic [31:0] fm_depth_q, am_depth_q;
  logic [24:0] sample_period_q;

  logic [31:0] phase_q, step_base_q, glide_goal_q, glide_inc_q;
  logic [31:0] progress_q, pstep_q, amplitude_q, rate_q;
  logic [CntW-1:0] counter_q;

  logic [31:0] fm_v_q, am_v_q, target_q, time_q;
  logic        out_valid_q;
  logic [31:0] sample_q;
  logic [24:0] tab_q;
  logic        neg_q;

  logic        accept;
  logic        glide_start;
  logic [31:0] am_half, mul_a, mul_b, mul_y;
  logic [31:0] sb_inc, prog_n, wave;
  logic        div_start, div_done;
  logic [gmo_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [gmo_pkg::DIV_DEN_W-1:0] div_den;
  logic [31:0] quot_sat;
  logic [63:0] recip_prod;
  logic [31:0] t_div;
  logic [31:0] half_phase;
  logic [SineTableBits-1:0] idx;
  logic [SineTableBits-3:0] rem_idx;
  logic [AddrW-1:0] tab_addr;
  logic        load_out;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign glide_start = accept && (func_i == gmo_pkg::FUNC_GLIDE) && !glide_time_i[31] &&
                       (glide_time_i != '0) && (step_base_q != '0);
  assign am_half    = 32'($signed(am_depth_q + {31'b0, am_depth_q[31]}) >>> 1);
  assign sb_inc     = (counter_q == '0) ? step_base_q + glide_inc_q : step_base_q;
  assign prog_n     = progress_q + pstep_q;
  assign quot_sat   = (div_quot[gmo_pkg::DIV_NUM_W-1:31] != '0) ? gmo_pkg::SAT_MAX
                                                                  : div_quot[31:0];
  assign recip_prod = 64'(time_q[30:0]) * 64'(RecipM[32:0]);
  assign t_div      = 32'(recip_prod >> (31 + RecipL));
  assign half_phase = 32'($signed(phase_q) >>> 1);
  assign load_out   = (state_q == ST_OUT_LOAD) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (waveform_q)
      gmo_pkg::WAVE_SINE:   idx = phase_q[23:24-SineTableBits];
      gmo_pkg::WAVE_COSINE: idx = phase_q[23:24-SineTableBits] + SineTableBits'(SinQ);
      gmo_pkg::WAVE_SMOOTH: idx = half_phase[23:24-SineTableBits] + SineTableBits'(SinQ);
      default:              idx = phase_q[23:24-SineTableBits];
    endcase
  end

  assign rem_idx  = idx[SineTableBits-3:0];
  assign tab_addr = idx[SineTableBits-2] ? AddrW'(SinQ) - {1'b0, rem_idx} : {1'b0, rem_idx};

  always_comb begin
    unique case (waveform_q)
      gmo_pkg::WAVE_SAW:    wave = {phase_q[30:0], 1'b0} - gmo_pkg::FX_ONE;
      gmo_pkg::WAVE_SINE,
      gmo_pkg::WAVE_COSINE,
      gmo_pkg::WAVE_SMOOTH: wave = neg_q ? 32'd0 - {7'b0, tab_q} : {7'b0, tab_q};
      gmo_pkg::WAVE_SQUARE: wave = ($signed(phase_q) < $signed(gmo_pkg::FX_HALF)) ?
                                   32'd0 - gmo_pkg::FX_ONE : gmo_pkg::FX_ONE;
      default:              wave = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_FM_MUL:  begin mul_a = fm_v_q;                   mul_b = fm_depth_q; end
      ST_AM_MUL:  begin mul_a = am_v_q;                   mul_b = am_half;    end
      ST_OUT_MUL,
      ST_OUT_LOAD: begin mul_a = amplitude_q;             mul_b = wave;       end
      default:    begin mul_a = target_q - step_base_q;   mul_b = rate_q;     end
    endcase
  end

  gmo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .y_o   (mul_y)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = {sample_period_q, 24'b0};
    div_den   = t_div;
    if (state_q == ST_DIV_T) begin
      div_start = 1'b1;
    end else if ((state_q == ST_DIV_RATE) && div_done) begin
      div_start = 1'b1;
      div_den   = time_q;
    end
  end

  gmo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == gmo_pkg::FUNC_SAMPLE)) begin
          state_d = ST_GLIDE;
        end else if (glide_start) begin
          state_d = ST_DIV_T;
        end
      end
      ST_GLIDE:    state_d = ST_FM_MUL;
      ST_FM_MUL:   state_d = ST_AM_MUL;
      ST_AM_MUL:   state_d = ST_WRAP;
      ST_WRAP:     state_d = ST_TAB;
      ST_TAB:      state_d = ST_OUT_MUL;
      ST_OUT_MUL:  state_d = ST_OUT_LOAD;
      ST_OUT_LOAD: if (load_out) state_d = ST_IDLE;
      ST_DIV_T:    state_d = ST_DIV_RATE;
      ST_DIV_RATE: if (div_done) state_d = ST_DIV_PROG;
      ST_DIV_PROG: if (div_done) state_d = ST_INC_MUL;
      ST_INC_MUL:  state_d = ST_INC_SET;
      ST_INC_SET:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      waveform_q      <= '0;
      fm_depth_q      <= '0;
      am_depth_q      <= '0;
      sample_period_q <= 25'h100_0000;
      phase_q         <= '0;
      step_base_q     <= '0;
      glide_goal_q    <= '0;
      glide_inc_q     <= '0;
      progress_q      <= gmo_pkg::FX_ONE;
      pstep_q         <= '0;
      counter_q       <= '0;
      amplitude_q     <= gmo_pkg::FX_ONE;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          gmo_pkg::CFG_WAVEFORM:      waveform_q      <= cfg_wdata_i[2:0];
          gmo_pkg::CFG_FM_DEPTH:      fm_depth_q      <= cfg_wdata_i;
          gmo_pkg::CFG_AM_DEPTH:      am_depth_q      <= cfg_wdata_i;
          gmo_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata_i[24:0];
          default: ;
        endcase
      end
      if (accept && (func_i == gmo_pkg::FUNC_RESET)) begin
        phase_q <= '0;
      end
      if (accept && (func_i == gmo_pkg::FUNC_GLIDE) && !glide_start) begin
        step_base_q <= target_step_i;
      end
      if ((state_q == ST_GLIDE) && ($signed(progress_q) < $signed(gmo_pkg::FX_ONE))) begin
        progress_q  <= prog_n;
        counter_q   <= (counter_q == CntW'(GlideDecimation - 1)) ? '0 : counter_q + 1'b1;
        step_base_q <= ($signed(prog_n) >= $signed(gmo_pkg::FX_ONE)) ? glide_goal_q : sb_inc;
      end
      if (state_q == ST_AM_MUL) begin
        phase_q <= phase_q + step_base_q + mul_y;
      end
      if (state_q == ST_WRAP) begin
        amplitude_q <= gmo_pkg::FX_ONE - am_half + mul_y;
        if ($signed(phase_q) > $signed(gmo_pkg::FX_ONE)) begin
          phase_q <= phase_q - gmo_pkg::FX_ONE;
        end
      end
      if ((state_q == ST_DIV_PROG) && div_done) begin
        pstep_q <= quot_sat;
      end
      if (state_q == ST_INC_SET) begin
        glide_inc_q  <= mul_y;
        glide_goal_q <= target_q;
        counter_q    <= '0;
        progress_q   <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fm_v_q   <= fm_voltage_i;
      am_v_q   <= am_voltage_i;
      target_q <= target_step_i;
      time_q   <= glide_time_i;
    end
    if ((state_q == ST_DIV_RATE) && div_done) begin
      rate_q <= quot_sat;
    end
    if (state_q == ST_TAB) begin
      tab_q <= QTab[tab_addr];
      neg_q <= idx[SineTableBits-1];
    end
    if (load_out) begin
      sample_q <= mul_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

FILE: test/glide_modulated_oscillator_tb.sv
// self-checking testbench for the glide modulated oscillator
// directed table then randomized phases, checked against an in-bench predictor
// depends on gmo_pkg and glide_modulated_oscillator
`timescale 1ns / 1ps

module glide_modulated_oscillator_tb;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = 2'd0;
  logic [31:0] fm_voltage_i = '0;
  logic [31:0] am_voltage_i = '0;
  logic [31:0] target_step_i = '0;
  logic [31:0] glide_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] sample_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = 2'd0;
  logic [31:0] cfg_wdata_i = '0;

  glide_modulated_oscillator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int          quarter_sine [0:256];
  logic [2:0]  p_wave;
  logic [31:0] p_fm_depth, p_am_depth, p_period;
  logic [31:0] p_phase, p_step, p_goal, p_inc, p_prog, p_prog_step, p_amp;
  logic [6:0]  p_count;

  logic [31:0] sample_q [$];
  int          errors = 0;
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned hold = 0;

  function automatic longint sx(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic logic [31:0] fxmul(longint a, longint b);
    longint p;
    p = a * b;
    return 32'(p >>> 24);
  endfunction

  function automatic logic [31:0] fxdiv(longint a, longint b);
    longint q;
    if (b == 0) return (a >= 0) ? gmo_pkg::SAT_MAX : 32'h8000_0000;
    q = (a * 64'sd16777216) / b;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return 32'(q);
  endfunction

  task automatic build_quarter_sine();
    longint unsigned x, term;
    longint sum;
    for (int i = 0; i <= 256; i++) begin
      x = (gmo_pkg::HALF_PI_Q30 * i) / 256;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      quarter_sine[i] = int'((longint'(sum) + 32) >>> 6);
    end
  endtask

  function automatic longint sine_at(int unsigned idx);
    int unsigned quad, r;
    idx = idx & 1023;
    quad = idx / 256;
    r = idx % 256;
    case (quad)
      0: return quarter_sine[r];
      1: return quarter_sine[256 - r];
      2: return -longint'(quarter_sine[r]);
      default: return -longint'(quarter_sine[256 - r]);
    endcase
  endfunction

  function automatic int unsigned table_index(logic [31:0] p);
    return (p >> 14) & 1023;
  endfunction

  function automatic longint wave_of(logic [31:0] p);
    longint v;
    v = sx(p);
    case (p_wave)
      gmo_pkg::WAVE_SAW:    return sx(fxmul(v, 2 * longint'(gmo_pkg::FX_ONE)) - gmo_pkg::FX_ONE);
      gmo_pkg::WAVE_SINE:   return sine_at(table_index(p));
      gmo_pkg::WAVE_COSINE: return sine_at(table_index(p) + 256);
      gmo_pkg::WAVE_SMOOTH:
        return sine_at(table_index(fxmul(v, longint'(gmo_pkg::FX_HALF))) + 256);
      gmo_pkg::WAVE_SQUARE:
        return (v < longint'(gmo_pkg::FX_HALF)) ? -longint'(gmo_pkg::FX_ONE)
                                                : longint'(gmo_pkg::FX_ONE);
      default:              return 0;
    endcase
  endfunction

  task automatic reset_predictor();
    p_wave = gmo_pkg::WAVE_SAW; p_fm_depth = '0; p_am_depth = '0; p_period = gmo_pkg::FX_ONE;
    p_phase = '0; p_step = '0; p_goal = '0; p_inc = '0;
    p_prog = gmo_pkg::FX_ONE; p_prog_step = '0; p_count = '0; p_amp = gmo_pkg::FX_ONE;
  endtask

  // advances predictor state for one beat; returns 1 when a sample is due
  task automatic oscillate(input logic [1:0] f, input logic [31:0] fm, am, tgt, tm,
                           output bit due, output logic [31:0] smp);
    logic [31:0] vstep, am_half, rate;
    longint t;
    due = 1'b0;
    smp = '0;
    case (f)
      gmo_pkg::FUNC_SAMPLE: begin
        if (sx(p_prog) < longint'(gmo_pkg::FX_ONE)) begin
          if (p_count == 0) p_step = p_step + p_inc;
          p_prog = p_prog + p_prog_step;
          p_count = (p_count == gmo_pkg::GLIDE_DECIMATION_DEF - 1) ? 7'd0 : p_count + 7'd1;
          if (sx(p_prog) >= longint'(gmo_pkg::FX_ONE)) p_step = p_goal;
        end
        vstep = p_step + fxmul(sx(fm), sx(p_fm_depth));
        am_half = 32'(sx(p_am_depth) / 2);
        p_amp = gmo_pkg::FX_ONE - am_half + fxmul(sx(am), sx(am_half));
        p_phase = p_phase + vstep;
        if (sx(p_phase) > longint'(gmo_pkg::FX_ONE)) p_phase = p_phase - gmo_pkg::FX_ONE;
        smp = fxmul(sx(p_amp), wave_of(p_phase));
        due = 1'b1;
      end
      gmo_pkg::FUNC_GLIDE: begin
        t = sx(tm);
        if (t <= 0 || p_step == 0) begin
          p_step = tgt;
        end else begin
          rate = fxdiv(longint'(p_period), t / gmo_pkg::GLIDE_DECIMATION_DEF);
          p_goal = tgt;
          p_inc = fxmul(sx(tgt - p_step), sx(rate));
          p_count = '0;
          p_prog = '0;
          p_prog_step = fxdiv(longint'(p_period), t);
        end
      end
      gmo_pkg::FUNC_RESET: p_phase = '0;
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  task automatic send(input logic [1:0] f, input logic [31:0] fm, am, tgt, tm,
                      input bit typed, input logic [31:0] typed_val);
    bit due;
    logic [31:0] smp;
    int unsigned g;
    in_valid_i <= 1'b1;
    func_i <= f;
    fm_voltage_i <= fm;
    am_voltage_i <= am;
    target_step_i <= tgt;
    glide_time_i <= tm;
    do @(posedge clk_i); while (!in_ready_o);
    oscillate(f, fm, am, tgt, tm, due, smp);
    if (due) sample_q.push_back(typed ? typed_val : smp);
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input gmo_pkg::cfg_e idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      gmo_pkg::CFG_WAVEFORM:      p_wave = data[2:0];
      gmo_pkg::CFG_FM_DEPTH:      p_fm_depth = data;
      gmo_pkg::CFG_AM_DEPTH:      p_am_depth = data;
      gmo_pkg::CFG_SAMPLE_PERIOD: p_period = {7'd0, data[24:0]};
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_beat();
    int unsigned r;
    logic [31:0] tm, tgt;
    r = $urandom_range(0, 99);
    if (r < 84) begin
      send(gmo_pkg::FUNC_SAMPLE, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
    end else if (r < 94) begin
      r = $urandom_range(0, 99);
      if (r < 50) tm = $urandom_range(32'h0001_0000, 32'h0200_0000);
      else if (r < 65) tm = $urandom;
      else if (r < 80) tm = $urandom_range(0, 99);
      else tm = -$urandom_range(0, 32'h7fff_ffff);
      r = $urandom_range(0, 99);
      if (r < 10) tgt = '0;
      else if (r < 70) tgt = $urandom_range(0, 32'h0010_0000) * (($urandom % 2) ? -1 : 1);
      else tgt = $urandom;
      send(gmo_pkg::FUNC_GLIDE, $urandom, $urandom, tgt, tm, 1'b0, '0);
    end else if (r < 97) begin
      send(gmo_pkg::FUNC_RESET, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
    end else begin
      send(gmo_pkg::FUNC_NONE, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls, mostly short
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hold != 0) begin
      hold <= hold - 1;
    end else if (calm || r < 60) begin
      out_ready_i <= 1'b1;
      hold <= $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b0;
      hold <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample beat: got %h", sample_o);
      end else begin
        want = sample_q.pop_front();
        if (sample_o !== want) begin
          errors++;
          if (errors <= 10) $display("sample mismatch: expected %h got %h", want, sample_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("glide_modulated_oscillator_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] fmd, amd;
    build_quarter_sine();
    reset_predictor();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saw at phase zero with unit amplitude gives minus one
    send(gmo_pkg::FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'hff00_0000);
    send(gmo_pkg::FUNC_NONE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
         1'b0, '0);
    send(gmo_pkg::FUNC_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 32'hff00_0000);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h0010_0000, 32'h8000_0000, 1'b0, '0);
    send(gmo_pkg::FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h0020_0000, 32'h0000_0063, 1'b0, '0);
    send(gmo_pkg::FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0);
    send(gmo_pkg::FUNC_SAMPLE, 32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0, 1'b0, '0);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h0004_0000, 32'h0000_0000, 1'b0, '0);
    send(gmo_pkg::FUNC_GLIDE, 32'h0, 32'h0, 32'h0001_0000, 32'h0100_0000, 1'b0, '0);
    for (int i = 0; i < 6; i++)
      send(gmo_pkg::FUNC_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 7);
      if (ph == 1) begin fmd = gmo_pkg::SAT_MAX; amd = 32'h8000_0000; end
      else if (ph == 2) begin fmd = 32'h8000_0000; amd = gmo_pkg::SAT_MAX; end
      else if (ph == 0) begin fmd = '0; amd = '0; end
      else if (ph == 6) begin fmd = $urandom; amd = $urandom; end
      else begin
        fmd = 32'($signed($urandom) >>> 10);
        amd = 32'($signed($urandom) >>> 6);
      end
      cfg_write(gmo_pkg::CFG_WAVEFORM, ph % 8);
      cfg_write(gmo_pkg::CFG_FM_DEPTH, fmd);
      cfg_write(gmo_pkg::CFG_AM_DEPTH, amd);
      if (ph == 3) cfg_write(gmo_pkg::CFG_SAMPLE_PERIOD, 32'h0);
      else if (ph == 4) cfg_write(gmo_pkg::CFG_SAMPLE_PERIOD, gmo_pkg::FX_ONE);
      else if (ph == 5)
        cfg_write(gmo_pkg::CFG_SAMPLE_PERIOD, $urandom_range(0, 32'h0100_0000));
      else cfg_write(gmo_pkg::CFG_SAMPLE_PERIOD, $urandom_range(1, 20000));
      for (int n = 0; n < 120; n++) random_beat();
      settle();
    end

    if (errors == 0 && sample_q.size() == 0) begin
      $display("glide_modulated_oscillator_tb: clean");
    end else begin
      $display("glide_modulated_oscillator_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/gmo_pkg.sv
src/gmo_mul.sv
src/gmo_div.sv
src/glide_modulated_oscillator.sv
test/glide_modulated_oscillator_tb.sv
